>>> hw/rtl/msrl_pkg.sv
package msrl_pkg;

  // item operations
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_SET_SPEED  = 2'd2,
    OP_E_BRAKE    = 2'd3
  } op_e;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ACCEL_STEP = 2'd0;
  localparam logic [1:0] REG_BRAKE_STEP = 2'd1;
  localparam logic [1:0] REG_MIN_SPEED  = 2'd2;
  localparam logic [1:0] REG_INVERT_DIR = 2'd3;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [6:0] AccelStepReset = 7'd10;
  localparam logic [6:0] BrakeStepReset = 7'd20;
  localparam logic [6:0] MinSpeedReset  = 7'd0;

  // speed limits
  localparam logic signed [9:0] SpeedMaxLimit = 10'sd100;
  localparam logic signed [9:0] SpeedMinLimit = -10'sd100;

  typedef struct packed {
    logic [6:0] accel_step;
    logic [6:0] brake_step;
    logic [6:0] min_speed;
    logic       invert_direction;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] cur_next;
    logic signed [7:0] tgt_next;
    logic              changed;
    logic              forward;
    logic [7:0]        magnitude;
  } result_t;

endpackage

>>> hw/rtl/msrl_regs.sv
module msrl_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msrl_pkg::ApbAddrW-1:0]   paddr,
  input  logic [msrl_pkg::ApbDataW-1:0]   pwdata,
  output logic [msrl_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  output msrl_pkg::cfg_t                  cfg_o
);

  msrl_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step       <= msrl_pkg::AccelStepReset;
      cfg_q.brake_step       <= msrl_pkg::BrakeStepReset;
      cfg_q.min_speed        <= msrl_pkg::MinSpeedReset;
      cfg_q.invert_direction <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        msrl_pkg::REG_ACCEL_STEP: cfg_q.accel_step       <= pwdata[6:0];
        msrl_pkg::REG_BRAKE_STEP: cfg_q.brake_step       <= pwdata[6:0];
        msrl_pkg::REG_MIN_SPEED:  cfg_q.min_speed        <= pwdata[6:0];
        msrl_pkg::REG_INVERT_DIR: cfg_q.invert_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      msrl_pkg::REG_ACCEL_STEP: prdata[6:0] = cfg_q.accel_step;
      msrl_pkg::REG_BRAKE_STEP: prdata[6:0] = cfg_q.brake_step;
      msrl_pkg::REG_MIN_SPEED:  prdata[6:0] = cfg_q.min_speed;
      msrl_pkg::REG_INVERT_DIR: prdata[0]   = cfg_q.invert_direction;
      default:                  prdata      = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/msrl_core.sv
module msrl_core (
  input  msrl_pkg::cfg_t    cfg_i,
  input  msrl_pkg::op_e     op_i,
  input  logic signed [7:0] val_i,
  input  logic signed [7:0] cur_i,
  input  logic signed [7:0] tgt_i,
  output msrl_pkg::result_t res_o
);

  logic [7:0]        cur_mag;
  logic [7:0]        tgt_mag;
  logic              accel;
  logic [6:0]        step_mag;
  logic signed [9:0] cur_ext;
  logic signed [9:0] tgt_ext;
  logic signed [9:0] step;
  logic signed [9:0] nxt;
  logic [9:0]        nxt_mag;
  logic signed [7:0] tick_speed;
  logic signed [9:0] tval;
  logic signed [7:0] tgt_clamped;
  logic signed [7:0] final_cur;

  assign cur_mag = cur_i[7] ? 8'(-cur_i) : 8'(cur_i);
  assign tgt_mag = tgt_i[7] ? 8'(-tgt_i) : 8'(tgt_i);
  assign cur_ext = 10'(cur_i);
  assign tgt_ext = 10'(tgt_i);

  // accelerating: same direction (or from zero) and magnitude grows
  assign accel = (cur_i != tgt_i) &&
                 !(cur_i[7] && (tgt_i > 8'sd0)) &&
                 !((cur_i > 8'sd0) && tgt_i[7]) &&
                 (tgt_mag > cur_mag);

  assign step_mag = accel ? cfg_i.accel_step : cfg_i.brake_step;
  assign step     = (tgt_i < cur_i) ? -$signed({3'b000, step_mag})
                                    :  $signed({3'b000, step_mag});
  assign nxt      = cur_ext + step;
  assign nxt_mag  = nxt[9] ? 10'(-nxt) : 10'(nxt);

  always_comb begin
    if (!accel && ({1'b0, step_mag} > cur_mag)) begin
      tick_speed = '0;                     // braking through zero stops first
    end else if (((nxt < tgt_ext) && (nxt < cur_ext)) ||
                 ((nxt > tgt_ext) && (nxt > cur_ext))) begin
      tick_speed = tgt_i;                  // overshoot lands on target
    end else if (nxt_mag < {3'b000, cfg_i.min_speed}) begin
      if (accel) begin
        tick_speed = nxt[9] ? 8'(-$signed({1'b0, cfg_i.min_speed}))
                            : $signed({1'b0, cfg_i.min_speed});
      end else begin
        tick_speed = '0;
      end
    end else if (nxt > msrl_pkg::SpeedMaxLimit) begin
      tick_speed = 8'(msrl_pkg::SpeedMaxLimit);
    end else if (nxt < msrl_pkg::SpeedMinLimit) begin
      tick_speed = 8'(msrl_pkg::SpeedMinLimit);
    end else begin
      tick_speed = nxt[7:0];
    end
  end

  // new target: optional negate, then clamp
  assign tval = cfg_i.invert_direction ? -10'(val_i) : 10'(val_i);

  always_comb begin
    if (tval > msrl_pkg::SpeedMaxLimit) begin
      tgt_clamped = 8'(msrl_pkg::SpeedMaxLimit);
    end else if (tval < msrl_pkg::SpeedMinLimit) begin
      tgt_clamped = 8'(msrl_pkg::SpeedMinLimit);
    end else begin
      tgt_clamped = tval[7:0];
    end
  end

  always_comb begin
    final_cur     = cur_i;
    res_o.tgt_next = tgt_i;
    res_o.changed  = 1'b0;
    case (op_i)
      msrl_pkg::OP_TICK: begin
        if (cur_i != tgt_i) begin
          final_cur     = tick_speed;
          res_o.changed = 1'b1;
        end
      end
      msrl_pkg::OP_SET_TARGET: res_o.tgt_next = tgt_clamped;
      msrl_pkg::OP_SET_SPEED:  final_cur      = val_i;
      msrl_pkg::OP_E_BRAKE:    final_cur      = '0;
      default:                 final_cur      = cur_i;
    endcase
    res_o.cur_next  = final_cur;
    res_o.forward   = !final_cur[7];
    res_o.magnitude = final_cur[7] ? 8'(-final_cur) : 8'(final_cur);
  end

endmodule

>>> hw/rtl/motor_speed_ramp_limiter.sv
// channel | handshake               | payload
// --------+-------------------------+---------------------------------------------
// in      | in_valid_i / in_ready_o | operation_i, speed_value_i
// out     | out_valid_o/out_ready_i | current_speed_o, speed_changed_o,
//         |                         | driving_forward_o, speed_magnitude_o
// cfg     | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// one item per cycle sustained while the output is not stalled; each transfer lands in
// an input register, and its result is computed into the output register when the
// input stage moves forward; the speed and target registers update on that same edge,
// so a following item in the next cycle sees them already
// rst_ni clears both handshake stages and the state; config returns to defaults
// a stalled output holds the input stage, which then takes a transfer only while it
// is empty; otherwise it takes one only when it moves forward in the same cycle
module motor_speed_ramp_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic signed [7:0]             speed_value_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [7:0]             current_speed_o,
  output logic                          speed_changed_o,
  output logic                          driving_forward_o,
  output logic [7:0]                    speed_magnitude_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msrl_pkg::ApbAddrW-1:0] paddr,
  input  logic [msrl_pkg::ApbDataW-1:0] pwdata,
  output logic [msrl_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  msrl_pkg::cfg_t    cfg;
  msrl_pkg::result_t res;

  // input stage
  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_op_q;
  logic signed [7:0] s1_val_q;

  // state
  logic signed [7:0] cur_q;
  logic signed [7:0] tgt_q;

  // output stage
  logic              out_valid_q, out_valid_d;
  logic signed [7:0] out_speed_q;
  logic              out_changed_q;
  logic              out_fwd_q;
  logic [7:0]        out_mag_q;

  logic in_xfer;
  logic s1_adv;

  msrl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msrl_core u_core (
    .cfg_i (cfg),
    .op_i  (msrl_pkg::op_e'(s1_op_q)),
    .val_i (s1_val_q),
    .cur_i (cur_q),
    .tgt_i (tgt_q),
    .res_o (res)
  );

  // the input stage moves on whenever the output register is empty or drains
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      tgt_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        cur_q <= res.cur_next;
        tgt_q <= res.tgt_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q  <= operation_i;
      s1_val_q <= speed_value_i;
    end
    if (s1_adv) begin
      out_speed_q   <= res.cur_next;
      out_changed_q <= res.changed;
      out_fwd_q     <= res.forward;
      out_mag_q     <= res.magnitude;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_speed_o   = out_speed_q;
  assign speed_changed_o   = out_changed_q;
  assign driving_forward_o = out_fwd_q;
  assign speed_magnitude_o = out_mag_q;

  // target never leaves the clamp range
  a_tgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tgt_q <= 8'sd100) && (tgt_q >= -8'sd100))
    else $error("target out of range");

  // a stage-one item always reaches the output register
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced item lost");

  // a held input stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_op_q) && $stable(s1_val_q)))
    else $error("input stage dropped item");

  // tick results always lie inside the signed magnitude range
  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_changed_q) |-> (out_speed_q != -8'sd128))
    else $error("tick result out of range");

  // output state mirrors the speed register after each result
  a_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_speed_q == cur_q))
    else $error("result and state disagree");

endmodule
